// ----- sv/fsp_pkg.sv -----
package fsp_pkg;

	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_H     = 8'h68;
	localparam logic [7:0] CH_L     = 8'h6C;
	localparam logic [7:0] CH_UL    = 8'h4C;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_J     = 8'h6A;
	localparam logic [7:0] CH_Z     = 8'h7A;

	localparam int unsigned FLAG_MINUS = 0;
	localparam int unsigned FLAG_PLUS  = 1;
	localparam int unsigned FLAG_HASH  = 2;
	localparam int unsigned FLAG_ZERO  = 3;
	localparam int unsigned FLAG_SPACE = 4;

	localparam logic [30:0] SAT_MAX = 31'h7FFF_FFFF;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_FLAGS = 3'd1,
		PH_WIDTH = 3'd2,
		PH_DOT   = 3'd3,
		PH_PDIG  = 3'd4,
		PH_LEN1  = 3'd5,
		PH_LEN2  = 3'd6,
		PH_CONV  = 3'd7
	} phase_t;

	typedef enum logic [3:0] {
		ACT_START,
		ACT_FLAG,
		ACT_WDIG,
		ACT_WSTAR,
		ACT_DOT,
		ACT_PDIG,
		ACT_PSTAR,
		ACT_LEN1,
		ACT_LEN2,
		ACT_EMIT
	} act_t;

	typedef struct packed {
		logic [7:0]         ch;
		logic signed [31:0] star_value;
	} in_t;

	typedef struct packed {
		logic        left_align;
		logic        force_sign;
		logic        alternate_form;
		logic        zero_pad;
		logic        space_sign;
		logic [30:0] field_width;
		logic        has_precision;
		logic [30:0] precision_value;
		logic [7:0]  length_first;
		logic [7:0]  length_second;
		logic [7:0]  conversion;
	} out_t;

	typedef struct packed {
		phase_t      phase;
		logic [4:0]  flags;
		logic [30:0] width_acc;
		logic [30:0] prec_acc;
		logic        dot_seen;
		logic [15:0] len_bytes;
	} st_t;

	localparam st_t ST_RESET = '{
		phase:     PH_IDLE,
		flags:     5'd0,
		width_acc: 31'd0,
		prec_acc:  31'd0,
		dot_seen:  1'b0,
		len_bytes: 16'd0
	};

	// acc * 10 + digit, saturating
	function automatic logic [30:0] acc_digit(input logic [30:0] acc, input logic [7:0] c);
		logic [34:0] v;
		begin
			v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {31'd0, c[3:0]} - 35'd0;
			acc_digit = (v > {4'd0, SAT_MAX}) ? SAT_MAX : v[30:0];
		end
	endfunction

	function automatic logic [30:0] star_mag(input logic signed [31:0] v);
		logic [31:0] m;
		begin
			m = ~v + 32'd1;
			if (v[31]) begin
				star_mag = m[31] ? SAT_MAX : m[30:0];
			end else begin
				star_mag = v[30:0];
			end
		end
	endfunction

endpackage

// ----- sv/format_spec_parser.sv -----
// output: a conversion character shows on rsp in the cycle after it is accepted
// throughput: one character per cycle unless stalled; the parse state register
// and the result register are the only storage, the step logic sits between them
// req_ready drops only while a result waits and rsp_ready is low
// reset: arst_n clears the parse state to idle and empties the result register
module format_spec_parser import fsp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  in_t  req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output out_t rsp
);

	st_t  state_q;
	st_t  nxt;
	logic emit;
	out_t res;
	out_t rsp_q;
	logic rsp_valid_q;
	logic accept;

	fsp_step u_step (
		.st   (state_q),
		.word (req),
		.nxt  (nxt),
		.emit (emit),
		.res  (res)
	);

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q <= nxt;
			end
			if (accept && emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- sv/fsp_step.sv -----
module fsp_step import fsp_pkg::*; (
	input  st_t  st,
	input  in_t  word,
	output st_t  nxt,
	output logic emit,
	output out_t res
);

	logic [7:0] c;
	logic       is_digit;
	logic       is_flag;
	logic       is_len1;
	logic       is_len2;
	logic [4:0] flag_set;
	act_t       len_act;
	act_t       act;
	phase_t     nxt_phase;

	assign c        = word.ch;
	assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
	assign is_flag  = c inside {CH_MINUS, CH_PLUS, CH_HASH, CH_ZERO, CH_SPACE};
	assign is_len1  = c inside {CH_H, CH_L, CH_UL, CH_T, CH_J, CH_Z};
	assign is_len2  = c inside {CH_H, CH_L};
	assign len_act  = is_len1 ? ACT_LEN1 : ACT_EMIT;

	always_comb begin
		flag_set = 5'd0;
		case (c)
			CH_MINUS: flag_set[FLAG_MINUS] = 1'b1;
			CH_PLUS:  flag_set[FLAG_PLUS]  = 1'b1;
			CH_HASH:  flag_set[FLAG_HASH]  = 1'b1;
			CH_ZERO:  flag_set[FLAG_ZERO]  = 1'b1;
			CH_SPACE: flag_set[FLAG_SPACE] = 1'b1;
			default:  flag_set = 5'd0;
		endcase
	end

	// decode what this character does
	always_comb begin
		act = ACT_EMIT;
		case (st.phase)
			PH_IDLE: act = ACT_START;
			PH_FLAGS, PH_WIDTH: begin
				if (st.phase == PH_FLAGS && is_flag) act = ACT_FLAG;
				else if (is_digit)                   act = ACT_WDIG;
				else if (c == CH_STAR)               act = ACT_WSTAR;
				else if (c == CH_DOT)                act = ACT_DOT;
				else                                 act = len_act;
			end
			PH_DOT: act = (c == CH_DOT) ? ACT_DOT : len_act;
			PH_PDIG: begin
				if (is_digit)          act = ACT_PDIG;
				else if (c == CH_STAR) act = ACT_PSTAR;
				else                   act = len_act;
			end
			PH_LEN1: act = len_act;
			PH_LEN2: act = is_len2 ? ACT_LEN2 : ACT_EMIT;
			PH_CONV: act = ACT_EMIT;
			default: act = ACT_EMIT;
		endcase
	end

	// next phase
	always_comb begin
		nxt_phase = st.phase;
		case (act)
			ACT_START: nxt_phase = PH_FLAGS;
			ACT_FLAG:  nxt_phase = PH_FLAGS;
			ACT_WDIG:  nxt_phase = PH_WIDTH;
			ACT_WSTAR: nxt_phase = PH_DOT;
			ACT_DOT:   nxt_phase = PH_PDIG;
			ACT_PDIG:  nxt_phase = PH_PDIG;
			ACT_PSTAR: nxt_phase = PH_LEN1;
			ACT_LEN1:  nxt_phase = PH_LEN2;
			ACT_LEN2:  nxt_phase = PH_CONV;
			ACT_EMIT:  nxt_phase = PH_IDLE;
			default:   nxt_phase = PH_IDLE;
		endcase
	end

	// datapath and result
	always_comb begin
		nxt.phase     = nxt_phase;
		nxt.flags     = st.flags;
		nxt.width_acc = st.width_acc;
		nxt.prec_acc  = st.prec_acc;
		nxt.dot_seen  = st.dot_seen;
		nxt.len_bytes = st.len_bytes;
		emit          = 1'b0;
		case (act)
			ACT_FLAG: nxt.flags = st.flags | flag_set;
			ACT_WDIG: nxt.width_acc = acc_digit(st.width_acc, c);
			ACT_WSTAR: begin
				nxt.width_acc = star_mag(word.star_value);
				nxt.flags[FLAG_MINUS] = st.flags[FLAG_MINUS] | word.star_value[31];
			end
			ACT_DOT: nxt.dot_seen = 1'b1;
			ACT_PDIG: nxt.prec_acc = acc_digit(st.prec_acc, c);
			ACT_PSTAR: begin
				nxt.prec_acc = star_mag(word.star_value);
				nxt.flags[FLAG_MINUS] = st.flags[FLAG_MINUS] | word.star_value[31];
			end
			ACT_LEN1: nxt.len_bytes = {8'd0, c};
			ACT_LEN2: nxt.len_bytes = {c, st.len_bytes[7:0]};
			ACT_EMIT: begin
				emit          = 1'b1;
				nxt.flags     = 5'd0;
				nxt.width_acc = 31'd0;
				nxt.prec_acc  = 31'd0;
				nxt.dot_seen  = 1'b0;
				nxt.len_bytes = 16'd0;
			end
			default: begin
			end
		endcase
	end

	assign res.left_align      = st.flags[FLAG_MINUS];
	assign res.force_sign      = st.flags[FLAG_PLUS];
	assign res.alternate_form  = st.flags[FLAG_HASH];
	assign res.zero_pad        = st.flags[FLAG_ZERO];
	assign res.space_sign      = st.flags[FLAG_SPACE];
	assign res.field_width     = st.width_acc;
	assign res.has_precision   = st.dot_seen;
	assign res.precision_value = st.prec_acc;
	assign res.length_first    = st.len_bytes[7:0];
	assign res.length_second   = st.len_bytes[15:8];
	assign res.conversion      = c;

endmodule
